// ----- hdl/tfp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Telemetry frame packer package
// Shared widths, register indexes, the controller/datapath interface types
// and the CRC-16/CCITT-FALSE byte update.
// ----------------------------------------------------------------------------
package tfp_pkg;

  localparam int unsigned WordW        = 16;
  localparam int unsigned IdxW         = 6;
  localparam int unsigned ByteW        = 8;
  localparam int unsigned CfgIdxW      = 8;
  localparam int unsigned PayloadWords = 31;  // payload words covered by the CRC

  localparam logic [IdxW-1:0]    MagicIdx = IdxW'(0);
  localparam logic [IdxW-1:0]    CrcIdx   = IdxW'(32);

  localparam logic [CfgIdxW-1:0] CfgMagicHigh = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgMagicLow  = CfgIdxW'(1);

  localparam logic [WordW-1:0]   CrcInit = 16'hFFFF;
  localparam logic [WordW-1:0]   CrcPoly = 16'h1021;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic            load;   // capture a new record and restart the CRC
    logic            emit;   // write the word at index into the output register
    logic [IdxW-1:0] index;
  } tfp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_valid;
  } tfp_status_t;

  // One byte of CRC-16/CCITT-FALSE, MSB first.
  function automatic logic [WordW-1:0] crc16_byte(input logic [WordW-1:0] crc,
                                                  input logic [ByteW-1:0] data);
    logic [WordW-1:0] c;
    c = crc ^ {data, {ByteW{1'b0}}};
    for (int b = 0; b < ByteW; b++) begin
      if (c[WordW-1]) begin
        c = {c[WordW-2:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[WordW-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/tfp_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Telemetry frame packer controller
// Sequences the 33 word slots of a frame and decides when a record is taken.
// ----------------------------------------------------------------------------
module tfp_ctrl
  import tfp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        out_stall_i,
  input  tfp_status_t      status_i,
  output tfp_cmd_t         cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_SEND
  } state_e;

  state_e          state_q;
  logic [IdxW-1:0] idx_q;
  logic            slot_free;
  logic            last_slot;
  logic            take_ok;
  logic            accept;

  // The output register can take a word when empty or while being drained.
  assign slot_free  = !status_i.out_valid || !out_stall_i;
  assign last_slot  = (state_q == ST_SEND) && (idx_q == CrcIdx) && slot_free;
  assign take_ok    = (state_q == ST_IDLE) || last_slot;
  assign in_stall_o = !take_ok;
  assign accept     = in_valid_i && take_ok;

  always_comb begin
    cmd_o.load  = accept;
    cmd_o.emit  = (state_q == ST_SEND) && slot_free;
    cmd_o.index = idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= MagicIdx;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_SEND;
            idx_q   <= MagicIdx;
          end
        end
        ST_SEND: begin
          if (slot_free) begin
            if (idx_q == CrcIdx) begin
              idx_q   <= MagicIdx;
              state_q <= accept ? ST_SEND : ST_IDLE;
            end else begin
              idx_q <= idx_q + IdxW'(1);
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
          idx_q   <= MagicIdx;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hdl/tfp_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Telemetry frame packer datapath
// Magic registers, payload word shifter, running CRC and output register.
// ----------------------------------------------------------------------------
module tfp_datapath
  import tfp_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [ByteW-1:0]   cfg_data_i,
  input  wire logic [63:0]        timestamp_us_i,
  input  wire logic [15:0]        sequence_number_i,
  input  wire logic [15:0]        flag_bits_i,
  input  wire logic [63:0]        position_angle_bits_i,
  input  wire logic [63:0]        force_speed_bits_i,
  input  wire logic [63:0]        vibration_xy_bits_i,
  input  wire logic [63:0]        vibz_temperature_bits_i,
  input  wire logic [63:0]        current_alpha_bits_i,
  input  wire logic [63:0]        quality_spare_bits_i,
  input  tfp_cmd_t                cmd_i,
  output tfp_status_t             status_o,
  input  wire logic               out_stall_i,
  output logic                    out_valid_o,
  output logic [WordW-1:0]        frame_word_o,
  output logic [IdxW-1:0]         word_index_o,
  output logic                    last_word_o
);

  logic [ByteW-1:0] magic_hi_q;
  logic [ByteW-1:0] magic_lo_q;
  logic [WordW-1:0] pay_q [PayloadWords];
  logic [WordW-1:0] pay_d [PayloadWords];
  logic [WordW-1:0] crc_q;
  logic [WordW-1:0] crc_d;
  logic [WordW-1:0] word_sel;
  logic             out_valid_q;
  logic [WordW-1:0] frame_word_q;
  logic [IdxW-1:0]  word_index_q;
  logic             last_word_q;
  logic [64*6-1:0]  floats;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_hi_q <= '0;
      magic_lo_q <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgMagicHigh) begin
        magic_hi_q <= cfg_data_i;
      end else if (cfg_index_i == CfgMagicLow) begin
        magic_lo_q <= cfg_data_i;
      end
    end
  end

  assign floats = {position_angle_bits_i, force_speed_bits_i, vibration_xy_bits_i,
                   vibz_temperature_bits_i, current_alpha_bits_i, quality_spare_bits_i};

  // Payload words in frame order; the head word leaves on each payload slot.
  always_comb begin
    if (cmd_i.load) begin
      pay_d[0] = timestamp_us_i[63:48];
      pay_d[1] = timestamp_us_i[47:32];
      pay_d[2] = timestamp_us_i[31:16];
      pay_d[3] = timestamp_us_i[15:0];
      pay_d[4] = sequence_number_i;
      pay_d[5] = flag_bits_i;
      for (int w = 0; w < 24; w++) begin
        pay_d[6+w] = floats[64*6-1-WordW*w -: WordW];
      end
      pay_d[PayloadWords-1] = '0;
    end else begin
      for (int w = 0; w < PayloadWords; w++) begin
        pay_d[w] = pay_q[w];
      end
      if (cmd_i.emit && (cmd_i.index != MagicIdx) && (cmd_i.index != CrcIdx)) begin
        for (int w = 0; w < PayloadWords - 1; w++) begin
          pay_d[w] = pay_q[w+1];
        end
        pay_d[PayloadWords-1] = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pay_q <= pay_d;
  end

  always_comb begin
    if (cmd_i.index == MagicIdx) begin
      word_sel = {magic_hi_q, magic_lo_q};
    end else if (cmd_i.index == CrcIdx) begin
      word_sel = crc_q;
    end else begin
      word_sel = pay_q[0];
    end
  end

  always_comb begin
    crc_d = crc_q;
    if (cmd_i.load) begin
      crc_d = CrcInit;
    end else if (cmd_i.emit && (cmd_i.index != MagicIdx) && (cmd_i.index != CrcIdx)) begin
      crc_d = crc16_byte(crc16_byte(crc_q, pay_q[0][WordW-1:ByteW]), pay_q[0][ByteW-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q <= crc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      frame_word_q <= word_sel;
      word_index_q <= cmd_i.index;
      last_word_q  <= (cmd_i.index == CrcIdx);
    end
  end

  assign status_o.out_valid = out_valid_q;
  assign out_valid_o        = out_valid_q;
  assign frame_word_o       = frame_word_q;
  assign word_index_o       = word_index_q;
  assign last_word_o        = last_word_q;

endmodule
`default_nettype wire

// ----- hdl/telemetry_frame_packer_crc16_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Telemetry frame packer with CRC-16/CCITT-FALSE
// Turns one telemetry record into a 66-byte frame sent as 33 big-endian
// 16-bit words: the magic word, 31 payload words and the CRC word.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake               Contents
//  -------  ---------  ----------------------  ---------------------------------
//  cfg      in         cfg_valid_i/cfg_ready_o  register index, 8-bit data
//  in       in         in_valid_i/in_stall_o    one telemetry record
//  out      out        out_valid_o/out_stall_i  frame_word, word_index, last_word
//
// A record is turned into 33 transfers, one per cycle while the output side
// does not stall; the output register that carries one word per cycle sets
// this rate. The next record is taken in the cycle the CRC word enters the
// output register, so frames follow back to back. The CRC advances by one
// payload word per emitted payload word and is ready when the CRC slot comes
// up. Reset clears the magic registers, the sequencer and the output valid;
// no clearing pass is needed. A stall on the output holds the current word
// and freezes the sequencer.
//
module telemetry_frame_packer_crc16_core
  import tfp_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Configuration writes; always ready.
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [ByteW-1:0]   cfg_data_i,
  // Record input.
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [63:0]        timestamp_us_i,
  input  wire logic [15:0]        sequence_number_i,
  input  wire logic [15:0]        flag_bits_i,
  input  wire logic [63:0]        position_angle_bits_i,
  input  wire logic [63:0]        force_speed_bits_i,
  input  wire logic [63:0]        vibration_xy_bits_i,
  input  wire logic [63:0]        vibz_temperature_bits_i,
  input  wire logic [63:0]        current_alpha_bits_i,
  input  wire logic [63:0]        quality_spare_bits_i,
  // Frame word output.
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [WordW-1:0]        frame_word_o,
  output logic [IdxW-1:0]         word_index_o,
  output logic                    last_word_o
);

  tfp_cmd_t    cmd;
  tfp_status_t status;

  // Registers are plain flops, so a write can land in any cycle.
  assign cfg_ready_o = 1'b1;

  tfp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tfp_datapath u_datapath (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .cfg_valid_i             (cfg_valid_i),
    .cfg_index_i             (cfg_index_i),
    .cfg_data_i              (cfg_data_i),
    .timestamp_us_i          (timestamp_us_i),
    .sequence_number_i       (sequence_number_i),
    .flag_bits_i             (flag_bits_i),
    .position_angle_bits_i   (position_angle_bits_i),
    .force_speed_bits_i      (force_speed_bits_i),
    .vibration_xy_bits_i     (vibration_xy_bits_i),
    .vibz_temperature_bits_i (vibz_temperature_bits_i),
    .current_alpha_bits_i    (current_alpha_bits_i),
    .quality_spare_bits_i    (quality_spare_bits_i),
    .cmd_i                   (cmd),
    .status_o                (status),
    .out_stall_i             (out_stall_i),
    .out_valid_o             (out_valid_o),
    .frame_word_o            (frame_word_o),
    .word_index_o            (word_index_o),
    .last_word_o             (last_word_o)
  );

endmodule
`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Telemetry frame packer testbench
// Sends telemetry records through the packer under random input gaps and
// output stalls, and compares every frame word it emits with a frame built
// in the bench, magic word and CRC-16/CCITT-FALSE included. The magic bytes
// are rewritten between batches, with writes to unused indexes mixed in.
// ----------------------------------------------------------------------------
module tb;
  import tfp_pkg::*;

  // One telemetry record, laid out as the input ports are.
  typedef struct packed {
    logic [63:0] timestamp_us;
    logic [15:0] sequence_number;
    logic [15:0] flag_bits;
    logic [63:0] position_angle_bits;
    logic [63:0] force_speed_bits;
    logic [63:0] vibration_xy_bits;
    logic [63:0] vibz_temperature_bits;
    logic [63:0] current_alpha_bits;
    logic [63:0] quality_spare_bits;
  } telemetry_rec_t;

  // One frame word as the output channel carries it.
  typedef struct packed {
    logic [WordW-1:0] word;
    logic [IdxW-1:0]  index;
    logic             last;
  } frame_word_t;

  // The first register index that maps to nothing; writes there are dropped.
  localparam logic [CfgIdxW-1:0] CfgFirstUnused = CfgMagicLow + 1'b1;
  localparam int unsigned        IdlePercent    = 14;
  localparam int unsigned        BodyBits       = 496;  // payload bytes 0..61
  localparam int unsigned        StuckLimit     = 5000;
  localparam int unsigned        DrainCycles    = 40;

  logic clk_i  = 1'b1;
  logic rst_ni = 1'b0;

  logic                 cfg_valid = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index = '0;
  logic [ByteW-1:0]     cfg_data  = '0;
  logic                 cfg_ready_o;

  logic                 rec_valid = 1'b0;
  telemetry_rec_t       rec_q     = '0;
  logic                 in_stall_o;

  logic                 out_stall = 1'b0;
  logic                 out_valid_o;
  logic [WordW-1:0]     frame_word_o;
  logic [IdxW-1:0]      word_index_o;
  logic                 last_word_o;

  // Bench copy of the two magic registers, updated on each accepted write.
  logic [ByteW-1:0]     magic_hi_copy = '0;
  logic [ByteW-1:0]     magic_lo_copy = '0;

  telemetry_rec_t       recs_pending[$];
  frame_word_t          words_due[$];
  int unsigned          recs_queued   = 0;
  int unsigned          recs_taken    = 0;
  int unsigned          mismatch_count = 0;
  int unsigned          stuck_cycles  = 0;
  // While set, neither side inserts gaps or stalls.
  bit                   calm = 1'b0;

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  telemetry_frame_packer_crc16_core dut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_valid_i            (cfg_valid),
    .cfg_ready_o            (cfg_ready_o),
    .cfg_index_i            (cfg_index),
    .cfg_data_i             (cfg_data),
    .in_valid_i             (rec_valid),
    .in_stall_o             (in_stall_o),
    .timestamp_us_i         (rec_q.timestamp_us),
    .sequence_number_i      (rec_q.sequence_number),
    .flag_bits_i            (rec_q.flag_bits),
    .position_angle_bits_i  (rec_q.position_angle_bits),
    .force_speed_bits_i     (rec_q.force_speed_bits),
    .vibration_xy_bits_i    (rec_q.vibration_xy_bits),
    .vibz_temperature_bits_i(rec_q.vibz_temperature_bits),
    .current_alpha_bits_i   (rec_q.current_alpha_bits),
    .quality_spare_bits_i   (rec_q.quality_spare_bits),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall),
    .frame_word_o           (frame_word_o),
    .word_index_o           (word_index_o),
    .last_word_o            (last_word_o)
  );

  // Builds the 33 words one record must produce and queues them. The CRC is
  // run bit by bit over payload bytes 0..61, MSB first, from the all-ones
  // seed, with no reflection and no final inversion.
  task automatic queue_frame_words(input telemetry_rec_t r);
    logic [BodyBits-1:0] body;
    logic [WordW-1:0]    crc;
    logic                feedback;
    frame_word_t         w;
    body = {r.timestamp_us, r.sequence_number, r.flag_bits,
            r.position_angle_bits, r.force_speed_bits, r.vibration_xy_bits,
            r.vibz_temperature_bits, r.current_alpha_bits, r.quality_spare_bits,
            16'h0000};
    crc = CrcInit;
    for (int i = BodyBits - 1; i >= 0; i--) begin
      feedback = crc[WordW-1] ^ body[i];
      crc = {crc[WordW-2:0], 1'b0} ^ (feedback ? CrcPoly : '0);
    end
    w.word  = {magic_hi_copy, magic_lo_copy};
    w.index = MagicIdx;
    w.last  = 1'b0;
    words_due.push_back(w);
    for (int k = 1; k <= PayloadWords; k++) begin
      w.word  = body[BodyBits - 1 - WordW * (k - 1) -: WordW];
      w.index = IdxW'(k);
      w.last  = 1'b0;
      words_due.push_back(w);
    end
    w.word  = crc;
    w.index = CrcIdx;
    w.last  = 1'b1;
    words_due.push_back(w);
  endtask

  task automatic report_mismatch(input string what, input logic [WordW-1:0] got,
                                 input logic [WordW-1:0] want);
    $display("ERROR %s: got %h, expected %h at %0t ns", what, got, want, $time);
    mismatch_count++;
  endtask

  // Record driver. A new record is presented once the previous one has been
  // taken; a held record never changes while the packer stalls it. Random
  // gaps are only inserted when nothing is being held.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rec_valid && !in_stall_o) begin
        queue_frame_words(rec_q);
        recs_taken++;
      end
      if (!rec_valid || !in_stall_o) begin
        if (recs_pending.size() != 0 && (calm || $urandom_range(99) >= IdlePercent)) begin
          rec_valid <= 1'b1;
          rec_q     <= recs_pending.pop_front();
        end else begin
          rec_valid <= 1'b0;
        end
      end
    end
  end

  // Frame word monitor. Each word taken by the bench is checked against the
  // oldest expected word, field by field. Output stalls are drawn here too.
  always @(posedge clk_i) begin
    frame_word_t want;
    if (rst_ni) begin
      out_stall <= !calm && ($urandom_range(99) < IdlePercent);
      if (out_valid_o && !out_stall) begin
        if (words_due.size() == 0) begin
          report_mismatch("frame word with nothing expected", frame_word_o, '0);
        end else begin
          want = words_due.pop_front();
          if (frame_word_o !== want.word) begin
            report_mismatch($sformatf("frame_word at index %0d", want.index),
                            frame_word_o, want.word);
          end
          if (word_index_o !== want.index) begin
            report_mismatch("word_index", WordW'(word_index_o), WordW'(want.index));
          end
          if (last_word_o !== want.last) begin
            report_mismatch($sformatf("last_word at index %0d", want.index),
                            WordW'(last_word_o), WordW'(want.last));
          end
        end
      end
    end
  end

  // Watchdog: ends the run if no transfer happens on any channel for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((rec_valid && !in_stall_o) || (out_valid_o && !out_stall) ||
          (cfg_valid && cfg_ready_o)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= StuckLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  // One register write. The bench copy follows only the indexes that exist,
  // so a write to an unused index must leave the frames unchanged.
  task automatic write_magic_reg(input logic [CfgIdxW-1:0] idx,
                                 input logic [ByteW-1:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CfgMagicHigh) begin
      magic_hi_copy = val;
    end else if (idx == CfgMagicLow) begin
      magic_lo_copy = val;
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_record(input telemetry_rec_t r);
    recs_pending.push_back(r);
    recs_queued++;
  endtask

  // Returns once every queued record has been taken and every frame word of
  // them has come out, so the packer is idle.
  task automatic wait_drained();
    while (recs_taken != recs_queued || words_due.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Same value in every field, cut to each field's width.
  function automatic telemetry_rec_t flat_record(input logic [63:0] v);
    telemetry_rec_t r;
    r.timestamp_us          = v;
    r.sequence_number       = v[15:0];
    r.flag_bits             = v[15:0];
    r.position_angle_bits   = v;
    r.force_speed_bits      = v;
    r.vibration_xy_bits     = v;
    r.vibz_temperature_bits = v;
    r.current_alpha_bits    = v;
    r.quality_spare_bits    = v;
    return r;
  endfunction

  // Mostly random words, with all-zero and all-one fields mixed in so that
  // extreme fields also show up next to random neighbours.
  function automatic logic [63:0] pick_word();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) begin
      return '0;
    end else if (roll < 20) begin
      return '1;
    end
    return {$urandom(), $urandom()};
  endfunction

  function automatic telemetry_rec_t random_record();
    telemetry_rec_t r;
    r.timestamp_us          = pick_word();
    r.sequence_number       = 16'(pick_word());
    r.flag_bits             = 16'(pick_word());
    r.position_angle_bits   = pick_word();
    r.force_speed_bits      = pick_word();
    r.vibration_xy_bits     = pick_word();
    r.vibz_temperature_bits = pick_word();
    r.current_alpha_bits    = pick_word();
    r.quality_spare_bits    = pick_word();
    return r;
  endfunction

  initial begin
    telemetry_rec_t r;
    logic [ByteW-1:0] hi_val;
    logic [ByteW-1:0] lo_val;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // With the magic registers still at their reset value of zero.
    send_record(flat_record('0));
    send_record(flat_record('1));
    send_record(flat_record({16{4'h5}}));
    wait_drained();

    // Magic at all ones; writes to unused indexes must be dropped.
    write_magic_reg(CfgMagicHigh, 8'hFF);
    write_magic_reg(CfgMagicLow, 8'hFF);
    write_magic_reg(CfgFirstUnused, 8'h00);
    write_magic_reg('1, 8'h00);

    // Field extremes: a single field at all ones with the rest at zero, or the reverse, so
    // every byte lane of the payload and the CRC is exercised on its own.
    send_record(flat_record({16{4'hA}}));
    r = flat_record('0); r.timestamp_us = '1;          send_record(r);
    r = flat_record('0); r.sequence_number = '1;       send_record(r);
    r = flat_record('0); r.flag_bits = '1;             send_record(r);
    r = flat_record('0); r.position_angle_bits = '1;   send_record(r);
    r = flat_record('0); r.force_speed_bits = '1;      send_record(r);
    r = flat_record('0); r.vibration_xy_bits = '1;     send_record(r);
    r = flat_record('0); r.vibz_temperature_bits = '1; send_record(r);
    r = flat_record('0); r.current_alpha_bits = '1;    send_record(r);
    r = flat_record('0); r.quality_spare_bits = '1;    send_record(r);
    r = flat_record('1); r.timestamp_us = '0;          send_record(r);
    r = flat_record('1); r.quality_spare_bits = '0;    send_record(r);
    wait_drained();

    // Random batches. The first two pin the magic bytes to opposite extremes;
    // one batch runs with no gaps or stalls so frames go back to back.
    for (int batch = 0; batch < 8; batch++) begin
      case (batch)
        0: begin
          hi_val = 8'h00;
          lo_val = 8'hFF;
        end
        1: begin
          hi_val = 8'hFF;
          lo_val = 8'h00;
        end
        default: begin
          hi_val = ByteW'($urandom());
          lo_val = ByteW'($urandom());
        end
      endcase
      write_magic_reg(CfgMagicHigh, hi_val);
      write_magic_reg(CfgMagicLow, lo_val);
      if ($urandom_range(1) == 1) begin
        write_magic_reg(CfgIdxW'($urandom_range(255, CfgFirstUnused)), ByteW'($urandom()));
      end
      calm = (batch == 3);
      repeat (50) send_record(random_record());
      wait_drained();
    end
    calm = 1'b0;

    // Let the packer settle; any stray word in this window is flagged.
    repeat (DrainCycles) @(posedge clk_i);
    if (words_due.size() != 0) begin
      report_mismatch("frame words never delivered", WordW'(words_due.size()), '0);
    end
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
